/* hw/rtl/fsct_pkg.sv */
// Shared types, constants and saturating helpers for the flow shop completion time core.
package fsct_pkg;

  localparam int PROC_W = 16;
  localparam int TIME_W = 32;
  localparam int JOB_W  = 12;
  localparam int MIDX_W = 4;
  localparam int CNT_W  = 5;
  localparam int KIND_W = 2;
  localparam int TDATA_W = 144;
  localparam int TUSER_W = 8;
  localparam int MACH_LIMIT = 16;
  localparam int JOB_LIMIT  = 4095;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_OP   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SPAN = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_JW,
    S_EMIT,
    S_SUM_RD,
    S_SUM_DIF,
    S_SUM_EMIT,
    S_FIN
  } state_t;

  // per-machine memory word
  typedef struct packed {
    logic [TIME_W-1:0] finish;
    logic [TIME_W-1:0] busy;
    logic [TIME_W-1:0] luf;
  } ent_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic calc_jw;
    logic emit_op;
    logic sum_rd;
    logic sum_dif;
    logic emit_idle;
    logic emit_fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic job_end;
    logic last_job;
    logic sweep_done;
    logic out_free;
  } sts_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

/* hw/rtl/fsct_ctrl.sv */
// Sequencing state machine for the flow shop completion time core.
module fsct_ctrl import fsct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_JW;
      end
      S_JW: begin
        cmd.calc_jw = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_op = 1'b1;
          state_nxt   = (sts.job_end && sts.last_job) ? S_SUM_RD : S_IDLE;
        end
      end
      S_SUM_RD: begin
        cmd.sum_rd = 1'b1;
        state_nxt  = S_SUM_DIF;
      end
      S_SUM_DIF: begin
        cmd.sum_dif = 1'b1;
        state_nxt   = S_SUM_EMIT;
      end
      S_SUM_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_idle = 1'b1;
          state_nxt     = sts.sweep_done ? S_FIN : S_SUM_RD;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit_fin = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/fsct_dp.sv */
// Datapath: machine memory, schedule accumulators and the result register.
module fsct_dp import fsct_pkg::*; #(
  parameter int MAX_MACHINES = 16,
  parameter int MAX_JOBS     = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [CNT_W-1:0]   cfg_data,
  input  logic [PROC_W-1:0]  in_proc,
  input  logic               in_last,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic [TUSER_W-1:0] out_tuser,
  output logic               out_tlast
);

  localparam int DEPTH   = (MAX_MACHINES < MACH_LIMIT) ? MAX_MACHINES : MACH_LIMIT;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int JOB_CAP = (MAX_JOBS - 1 > JOB_LIMIT) ? JOB_LIMIT : MAX_JOBS - 1;

  // machine count register
  logic [CNT_W-1:0] cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CNT_W'(1);
    end else if (cfg_valid) begin
      cfg_r <= cfg_data;
    end
  end

  // schedule state
  logic [TIME_W-1:0] left_finish_r, job_busy_r, job_luf_r, wait_acc_r, idle_sum_r;
  logic [AW-1:0]     mc_r, m_r, last_m_r, idx_r;
  logic [JOB_W-1:0]  job_cnt_r, cur_job_r;
  logic [PROC_W-1:0] p_r;
  logic              last_r, job_end_r;
  logic [TIME_W-1:0] c_r, jw_r, id_r;

  // memory and its valid bits
  ent_t             mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  ent_t             rd_ent_r;
  logic             rd_vld_r;

  // effective count and machine select
  logic [CNT_W-1:0] cnt, last_m5;
  logic [AW-1:0]    m_sel;

  always_comb begin
    if (cfg_r == '0) begin
      cnt = CNT_W'(1);
    end else if (cfg_r > CNT_W'(DEPTH)) begin
      cnt = CNT_W'(DEPTH);
    end else begin
      cnt = cfg_r;
    end
    last_m5 = cnt - CNT_W'(1);
    m_sel   = (CNT_W'(mc_r) >= last_m5) ? last_m5[AW-1:0] : mc_r;
  end

  // operation arithmetic
  ent_t              ent, wr_ent;
  logic [TIME_W-1:0] up, left, mx, c, p32;

  always_comb begin
    ent    = rd_vld_r ? rd_ent_r : '0;
    p32    = TIME_W'(p_r);
    up     = ent.finish;
    left   = (m_r == '0) ? '0 : left_finish_r;
    mx     = (left > up) ? left : up;
    c      = sat_add(mx, p32);
    wr_ent = ent;
    wr_ent.finish = c;
    if (p_r != '0) begin
      wr_ent.busy = sat_add(ent.busy, p32);
      wr_ent.luf  = c;
    end
  end

  // memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      mem[m_r] <= wr_ent;
    end
    if (cmd.accept || cmd.sum_rd) begin
      rd_ent_r <= mem[cmd.accept ? m_sel : idx_r];
      rd_vld_r <= valid_r[cmd.accept ? m_sel : idx_r];
    end
  end

  logic out_free;
  assign out_free = !out_tvalid || out_tready;

  // schedule registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      left_finish_r <= '0;
      job_busy_r    <= '0;
      job_luf_r     <= '0;
      wait_acc_r    <= '0;
      idle_sum_r    <= '0;
      mc_r          <= '0;
      job_cnt_r     <= '0;
      idx_r         <= '0;
    end else begin
      if (cmd.exec) begin
        valid_r[m_r]  <= 1'b1;
        left_finish_r <= c;
        if (p_r != '0) begin
          job_busy_r <= sat_add(job_busy_r, p32);
          job_luf_r  <= c;
        end
      end
      if (cmd.emit_op) begin
        if (job_end_r) begin
          wait_acc_r <= sat_add(wait_acc_r, jw_r);
          job_busy_r <= '0;
          job_luf_r  <= '0;
          mc_r       <= '0;
          if (job_cnt_r < JOB_W'(JOB_CAP)) begin
            job_cnt_r <= job_cnt_r + JOB_W'(1);
          end
          if (last_r) begin
            idx_r      <= '0;
            idle_sum_r <= '0;
          end
        end else begin
          mc_r <= m_r + AW'(1);
        end
      end
      if (cmd.emit_idle) begin
        idle_sum_r <= sat_add(idle_sum_r, id_r);
        if (idx_r != last_m_r) begin
          idx_r <= idx_r + AW'(1);
        end
      end
      if (cmd.emit_fin) begin
        valid_r       <= '0;
        left_finish_r <= '0;
        job_busy_r    <= '0;
        job_luf_r     <= '0;
        wait_acc_r    <= '0;
        mc_r          <= '0;
        job_cnt_r     <= '0;
      end
    end
  end

  // per-item holding registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_r       <= in_proc;
      last_r    <= in_last;
      m_r       <= m_sel;
      last_m_r  <= last_m5[AW-1:0];
      job_end_r <= (m_sel == last_m5[AW-1:0]);
      cur_job_r <= job_cnt_r;
    end
    if (cmd.exec) begin
      c_r <= c;
    end
    if (cmd.calc_jw) begin
      jw_r <= sat_sub(job_luf_r, job_busy_r);
    end
    if (cmd.sum_dif) begin
      id_r <= rd_vld_r ? sat_sub(rd_ent_r.luf, rd_ent_r.busy) : '0;
    end
  end

  // result register
  logic              load;
  logic [KIND_W-1:0] o_kind;
  logic [MIDX_W-1:0] o_mach;
  logic [TIME_W-1:0] o_time, o_jw, o_tw, o_ti;
  logic              o_wv, o_last;

  always_comb begin
    load   = cmd.emit_op || cmd.emit_idle || cmd.emit_fin;
    o_kind = KIND_OP;
    o_mach = MIDX_W'(m_r);
    o_time = c_r;
    o_wv   = 1'b0;
    o_jw   = '0;
    o_tw   = '0;
    o_ti   = '0;
    o_last = 1'b1;
    if (cmd.emit_op) begin
      o_wv   = job_end_r;
      o_jw   = job_end_r ? jw_r : '0;
      o_last = !(job_end_r && last_r);
    end else if (cmd.emit_idle) begin
      o_kind = KIND_IDLE;
      o_mach = MIDX_W'(idx_r);
      o_time = id_r;
      o_last = 1'b0;
    end else if (cmd.emit_fin) begin
      o_kind = KIND_SPAN;
      o_mach = '0;
      o_time = left_finish_r;
      o_tw   = wait_acc_r;
      o_ti   = idle_sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata <= {o_ti, o_tw, o_jw, o_time, o_mach, cur_job_r};
      out_tuser <= {{(TUSER_W - KIND_W - 1){1'b0}}, o_wv, o_kind};
      out_tlast <= o_last;
    end
  end

  // status
  always_comb begin
    sts.job_end    = job_end_r;
    sts.last_job   = last_r;
    sts.sweep_done = (idx_r == last_m_r);
    sts.out_free   = out_free;
  end

endmodule

/* hw/rtl/flow_shop_completion_times_core.sv */
// Top level of the flow shop completion time core.
// Each accepted operation word is handled in order: the machine's entry is read from the
// machine memory, the max-and-add gives its completion time, the job wait is subtracted
// and the result is loaded. No new word is taken until the last one is through.
// An operation that ends the final job adds the end-of-schedule summary: per machine a
// memory read, an idle subtraction and a result load, then the makespan word, after which
// the valid bits, job count and job and wait accumulators are back at their reset value.
// A result waiting on out_tready stalls only the step that loads the next result.
module flow_shop_completion_times_core import fsct_pkg::*; #(
  parameter int MAX_MACHINES = 16,
  parameter int MAX_JOBS     = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration: machine_count
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_data,
  // operations
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [PROC_W-1:0]  in_tdata,   // [15:0] proc_time
  input  logic               in_tlast,   // last_job
  // results
  output logic               out_tvalid,
  input  logic               out_tready,
  // [11:0] job_position, [15:12] machine_index, [47:16] time_value,
  // [79:48] job_wait, [111:80] total_wait, [143:112] total_idle
  output logic [TDATA_W-1:0] out_tdata,
  // [1:0] result_kind, [2] job_wait_valid, [7:3] zero
  output logic [TUSER_W-1:0] out_tuser,
  output logic               out_tlast   // last_result
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fsct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsct_dp #(
    .MAX_MACHINES (MAX_MACHINES),
    .MAX_JOBS     (MAX_JOBS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_proc    (in_tdata),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // an accepted word keeps the input closed for the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an operation is in progress");

  // idle summaries never close a step
  a_idle_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_IDLE |-> !out_tlast)
    else $error("idle summary marked as final result");

  // the makespan word always closes its step
  a_span_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_SPAN |-> out_tlast)
    else $error("makespan word not marked as final result");

  // job wait is only carried on operation results
  a_wait_on_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == KIND_OP)
    else $error("job wait flagged on a summary word");
`endif

endmodule

/* bench/tb_flow_shop_completion_times_core.sv */
// Self-checking bench for the flow shop completion time core: predicted result words vs DUT.
`timescale 1ns / 100ps

module tb_flow_shop_completion_times_core;
  import fsct_pkg::*;

  // one operation word as offered on the input stream
  typedef struct packed {
    logic [PROC_W-1:0] proc;
    logic              fin;
  } op_word_t;

  // one result word, unpacked into its fields
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [JOB_W-1:0]  job;
    logic [MIDX_W-1:0] mach;
    logic [TIME_W-1:0] tval;
    logic              wvalid;
    logic [TIME_W-1:0] jwait;
    logic [TIME_W-1:0] twait;
    logic [TIME_W-1:0] tidle;
    logic              last_word;
  } sched_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_data = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [PROC_W-1:0]  in_tdata = '0;   // [15:0] proc_time
  logic               in_tlast = 1'b0; // last_job
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;       // [11:0] job, [15:12] machine, [47:16] time,
                                       // [79:48] job wait, [111:80] total wait, [143:112] idle
  logic [TUSER_W-1:0] out_tuser;       // [1:0] kind, [2] job_wait_valid
  logic               out_tlast;       // last_result

  flow_shop_completion_times_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and expectation stores
  op_word_t    ops_to_send[$];
  sched_word_t schedule_results_q[$];
  int          ops_total = 0;
  int          ops_done = 0;
  int          fail_count = 0;

  // generator-side view of the machine position, kept apart from the predictor
  int          gen_pos = 0;
  logic [CNT_W-1:0] machines_cfg = 5'd1;

  // predicted schedule state
  logic [TIME_W-1:0] mach_fin[MACH_LIMIT];
  logic [TIME_W-1:0] mach_busy[MACH_LIMIT];
  logic [TIME_W-1:0] mach_used_fin[MACH_LIMIT];
  logic [TIME_W-1:0] chain_fin;
  logic [TIME_W-1:0] job_busy;
  logic [TIME_W-1:0] job_used_fin;
  logic [TIME_W-1:0] wait_sum;
  logic [JOB_W-1:0]  job_pos;
  int                op_mach;

  function automatic int active_machines();
    if (machines_cfg == 0) return 1;
    if (machines_cfg > MACH_LIMIT) return MACH_LIMIT;
    return int'(machines_cfg);
  endfunction

  function automatic logic [TIME_W-1:0] add_clamp(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] diff_floor(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic void clear_schedule();
    int i;
    for (i = 0; i < MACH_LIMIT; i++) begin
      mach_fin[i] = '0;
      mach_busy[i] = '0;
      mach_used_fin[i] = '0;
    end
    chain_fin = '0;
    job_busy = '0;
    job_used_fin = '0;
    wait_sum = '0;
    job_pos = '0;
    op_mach = 0;
  endfunction

  function automatic void expect_word(input logic [KIND_W-1:0] kind, input logic [JOB_W-1:0] job,
                                      input int mach, input logic [TIME_W-1:0] tval,
                                      input logic wv, input logic [TIME_W-1:0] jw,
                                      input logic [TIME_W-1:0] tw, input logic [TIME_W-1:0] ti,
                                      input logic lst);
    sched_word_t w;
    w.kind = kind;
    w.job = job;
    w.mach = mach[MIDX_W-1:0];
    w.tval = tval;
    w.wvalid = wv;
    w.jwait = jw;
    w.twait = tw;
    w.tidle = ti;
    w.last_word = lst;
    schedule_results_q.insert(schedule_results_q.size(), w);
  endfunction

  // completion time of one operation, plus job wait and end-of-schedule summary
  function automatic void schedule_op(input logic [PROC_W-1:0] p, input logic fin);
    int cnt;
    int m;
    int i;
    logic [TIME_W-1:0] left, up, c, jw, idle, idle_sum;
    logic [JOB_W-1:0] pos;
    cnt = active_machines();
    m = (op_mach >= cnt) ? cnt - 1 : op_mach;
    pos = job_pos;
    left = (m == 0) ? '0 : chain_fin;
    up = mach_fin[m];
    c = add_clamp((left > up) ? left : up, {{(TIME_W-PROC_W){1'b0}}, p});
    mach_fin[m] = c;
    chain_fin = c;
    if (p != 0) begin
      mach_busy[m] = add_clamp(mach_busy[m], {{(TIME_W-PROC_W){1'b0}}, p});
      mach_used_fin[m] = c;
      job_busy = add_clamp(job_busy, {{(TIME_W-PROC_W){1'b0}}, p});
      job_used_fin = c;
    end
    if (m + 1 < cnt) begin
      expect_word(KIND_OP, pos, m, c, 1'b0, '0, '0, '0, 1'b1);
      op_mach = m + 1;
    end else begin
      jw = diff_floor(job_used_fin, job_busy);
      expect_word(KIND_OP, pos, m, c, 1'b1, jw, '0, '0, !fin);
      wait_sum = add_clamp(wait_sum, jw);
      job_busy = '0;
      job_used_fin = '0;
      op_mach = 0;
      if (job_pos < JOB_LIMIT) job_pos = job_pos + 1'b1;
      // final job closes the schedule: per-machine idle, then makespan
      if (fin) begin
        idle_sum = '0;
        for (i = 0; i < cnt; i++) begin
          idle = diff_floor(mach_used_fin[i], mach_busy[i]);
          idle_sum = add_clamp(idle_sum, idle);
          expect_word(KIND_IDLE, pos, i, idle, 1'b0, '0, '0, '0, 1'b0);
        end
        expect_word(KIND_SPAN, pos, 0, chain_fin, 1'b0, '0, wait_sum, idle_sum, 1'b1);
        clear_schedule();
      end
    end
  endfunction

  initial clear_schedule();

  function automatic string show(input sched_word_t w);
    return $sformatf("kind=%0d job=%0d mach=%0d t=%0d wv=%0d jw=%0d tw=%0d ti=%0d last=%0d",
                     w.kind, w.job, w.mach, w.tval, w.wvalid, w.jwait, w.twait, w.tidle,
                     w.last_word);
  endfunction

  function automatic void note_failure(input string msg);
    if (fail_count < 10) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // does the next operation end its job under the current count
  function automatic bit ends_job();
    int cnt;
    int m;
    cnt = active_machines();
    m = (gen_pos >= cnt) ? cnt - 1 : gen_pos;
    return (m + 1 >= cnt);
  endfunction

  function automatic void add_op(input logic [PROC_W-1:0] p, input logic fin);
    op_word_t w;
    int cnt;
    int m;
    cnt = active_machines();
    m = (gen_pos >= cnt) ? cnt - 1 : gen_pos;
    gen_pos = (m + 1 >= cnt) ? 0 : m + 1;
    w.proc = p;
    w.fin = fin;
    ops_to_send.insert(ops_to_send.size(), w);
    ops_total++;
  endfunction

  function automatic logic [PROC_W-1:0] pick_proc(input int zero_pct);
    int r;
    logic [PROC_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < zero_pct) v = '0;
    else if (r < zero_pct + 45) v = PROC_W'($urandom_range(1, 25));
    else if (r < 96) v = PROC_W'($urandom);
    else v = '1;
    return v;
  endfunction

  // whole jobs with random times; the last bit only closes on the final job's end
  function automatic void add_jobs(input int n_jobs, input bit close);
    int j;
    bit e;
    for (j = 0; j < n_jobs; j++) begin
      e = 1'b0;
      while (!e) begin
        e = ends_job();
        if (e) add_op(pick_proc(15), close && (j == n_jobs - 1));
        else add_op(pick_proc(15), $urandom_range(0, 9) == 0);
      end
    end
  endfunction

  task automatic set_machine_count(input logic [CNT_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    machines_cfg = v;
  endtask

  // wait until every word has gone in and every predicted word has come out
  task automatic settle(input int tail);
    while (ops_done != ops_total || schedule_results_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- input driver

  op_word_t op_next;
  int       gap_left = 0;
  int       burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        ops_done++;
        schedule_op(in_tdata, in_tlast);
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (ops_to_send.size() > 0) begin
        op_next = ops_to_send.pop_front();
        in_tdata <= op_next.proc;
        in_tlast <= op_next.fin;
        in_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= $urandom_range(0, 7);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // long hold-off, counted on its own, started by toggling hold_req
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_left <= 500;
      hold_seen <= hold_req;
    end
  end

  // stall rate is redrawn whenever its countdown runs out, zero included
  int rx_left = 0;
  int rx_pct = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_left <= $urandom_range(50, 300);
        case ($urandom_range(0, 3))
          0: rx_pct <= 0;
          1: rx_pct <= 25;
          2: rx_pct <= 55;
          default: rx_pct <= 85;
        endcase
      end else begin
        rx_left <= rx_left - 1;
      end
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_pct);
    end
  end

  // ---------------------------------------------------------------- result monitor

  sched_word_t got;
  sched_word_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser[1:0];
      got.wvalid = out_tuser[2];
      got.job = out_tdata[11:0];
      got.mach = out_tdata[15:12];
      got.tval = out_tdata[47:16];
      got.jwait = out_tdata[79:48];
      got.twait = out_tdata[111:80];
      got.tidle = out_tdata[143:112];
      got.last_word = out_tlast;
      if (schedule_results_q.size() == 0) begin
        note_failure({"result word with none predicted: ", show(got)});
      end else begin
        want = schedule_results_q.pop_front();
        if (got.kind !== want.kind || got.job !== want.job || got.mach !== want.mach ||
            got.tval !== want.tval || got.wvalid !== want.wvalid ||
            got.jwait !== want.jwait || got.twait !== want.twait ||
            got.tidle !== want.tidle || got.last_word !== want.last_word) begin
          note_failure({"mismatch\n  exp ", show(want), "\n  got ", show(got)});
        end
      end
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin : stimulus
    int k;
    int target;
    logic [CNT_W-1:0] v;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count at its reset value of one: skipped op, max time, close
    add_op(16'h0000, 1'b0);
    add_op(16'hFFFF, 1'b0);
    add_op(16'h0001, 1'b1);
    settle(8);

    // job without any nonzero op, then extremes with a stray last bit mid-job
    set_machine_count(5'd3);
    add_op(16'h0000, 1'b0);
    add_op(16'h0000, 1'b0);
    add_op(16'h0000, 1'b0);
    add_op(16'hFFFF, 1'b1);
    add_op(16'h0001, 1'b0);
    add_op(16'hFFFF, 1'b1);
    settle(8);

    // count shrinks mid-job; machine 1 is never used in this schedule
    set_machine_count(5'd4);
    add_op(16'h0005, 1'b0);
    add_op(16'h0000, 1'b0);
    settle(8);
    set_machine_count(5'd2);
    add_op(16'h0000, 1'b0);
    add_op(16'h0003, 1'b0);
    add_op(16'h0000, 1'b1);
    settle(8);

    // random schedules over a spread of counts, out-of-range ones included
    for (k = 0; k < 10; k++) begin
      case (k)
        0: v = 5'd1;
        1: v = 5'd2;
        2: v = 5'd16;
        3: v = 5'd31;
        4: v = 5'd0;
        5: v = 5'd5;
        6: v = 5'd17;
        7: v = 5'd3;
        default: v = CNT_W'($urandom_range(0, 31));
      endcase
      set_machine_count(v);
      target = ops_total + 16;
      while (ops_total < target) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 3)) add_op(pick_proc(20), $urandom_range(0, 3) == 0);
        end else begin
          add_jobs($urandom_range(1, 2), $urandom_range(0, 3) != 0);
        end
      end
      settle(8);
    end

    // receiver holds off while full-width jobs keep coming
    set_machine_count(5'd16);
    hold_req <= ~hold_req;
    add_jobs(3, 1'b1);
    settle(8);

    // fresh schedule after the stalled one
    set_machine_count(CNT_W'($urandom_range(1, 16)));
    add_jobs(3, 1'b1);
    settle(80);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule
